@@ rtl/ogl_pkg.sv @@
// ogl_pkg: types, command codes and register indexes for the occupancy grid
// log-odds update block
// no dependencies
package ogl_pkg;

  localparam int unsigned CellW     = 16;
  localparam int unsigned CoordW    = 8;
  localparam int unsigned LinW      = 16;
  localparam int unsigned GridRegW  = 9;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned MaxSideDefault = 256;

  localparam logic [GridRegW-1:0] GridWidthReset  = 9'd256;
  localparam logic [GridRegW-1:0] GridHeightReset = 9'd256;
  localparam logic signed [CellW-1:0] ClampLowReset  = -16'sd2038;
  localparam logic signed [CellW-1:0] ClampHighReset = 16'sd3562;

  typedef enum logic [2:0] {
    CMD_READ     = 3'd0,
    CMD_ADD_XY   = 3'd1,
    CMD_ADD_IDX  = 3'd2,
    CMD_SET      = 3'd3,
    CMD_SET_LOW  = 3'd4,
    CMD_SET_HIGH = 3'd5
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_CLAMP_LOW   = 2'd2,
    REG_CLAMP_HIGH  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]              command;
    logic [CoordW-1:0]       cell_x;
    logic [CoordW-1:0]       cell_y;
    logic [LinW-1:0]         linear_index;
    logic signed [CellW-1:0] delta_value;
  } ogl_in_t;

  typedef struct packed {
    logic signed [CellW-1:0] cell_value;
    logic                    out_of_range;
  } ogl_out_t;

endpackage

@@ rtl/occupancy_grid_logodds_update.sv @@
// occupancy_grid_logodds_update: log-odds occupancy grid held in one
// synchronous cell memory, read-modify-write with one-deep forwarding
// depends on ogl_pkg
//
//   channel | signals                          | item
//   --------+----------------------------------+----------------------------
//   in      | in_valid_i / in_ready_o          | ogl_in_t command
//   out     | out_valid_o / out_ready_i        | ogl_out_t result
//   cfg     | cfg_we_i, cfg_index_i, cfg_wdata_i | register write, no wait
//
// an item is first addressed and read from memory, then modified, written
// back and loaded into the output register; items overlap, so one item per
// cycle is sustained while the output does not stall. back-to-back updates
// of one cell are forwarded from the last write. after reset a clearing pass
// writes zero to all MAX_SIDE*MAX_SIDE cells, one per cycle, with in_ready_o
// low. a stalled output holds the pipeline and blocks input.
module occupancy_grid_logodds_update
  import ogl_pkg::*;
#(
  parameter int unsigned MAX_SIDE = MaxSideDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ogl_in_t             in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ogl_out_t            out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned Depth = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned SideW = $clog2(MAX_SIDE + 1);
  localparam int unsigned AreaW = 2 * SideW;

  // configuration registers
  logic [GridRegW-1:0]     grid_width_q, grid_height_q;
  logic signed [CellW-1:0] clamp_low_q, clamp_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GridWidthReset;
      grid_height_q <= GridHeightReset;
      clamp_low_q   <= ClampLowReset;
      clamp_high_q  <= ClampHighReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i[GridRegW-1:0];
        REG_GRID_HEIGHT: grid_height_q <= cfg_wdata_i[GridRegW-1:0];
        REG_CLAMP_LOW:   clamp_low_q   <= cfg_wdata_i;
        REG_CLAMP_HIGH:  clamp_high_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sides limited to MAX_SIDE
  logic [SideW-1:0] side_w, side_h;
  logic [AreaW-1:0] area;

  always_comb begin
    if (32'(grid_width_q) > MAX_SIDE) side_w = SideW'(MAX_SIDE);
    else                              side_w = SideW'(grid_width_q);
    if (32'(grid_height_q) > MAX_SIDE) side_h = SideW'(MAX_SIDE);
    else                               side_h = SideW'(grid_height_q);
    area = AreaW'(side_w) * AreaW'(side_h);
  end

  // stage 0: address decode
  logic             clearing_q;
  logic [AddrW-1:0] clr_cnt_q;
  logic             s1_valid_q, s1_adv, in_accept;
  cmd_e             s1_cmd_q;
  logic             s1_ok_q;
  logic [AddrW-1:0] s1_addr_q;
  logic signed [CellW-1:0] s1_delta_q;
  logic             out_valid_q;
  ogl_out_t         out_item_q;

  logic             in_ok;
  logic [AddrW-1:0] in_addr;
  logic [AreaW-1:0] xy_index;
  logic [31:0]      lin_ext, xy_ext;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clearing_q && (!s1_valid_q || s1_adv);
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    xy_index = AreaW'(in_item_i.cell_y) * AreaW'(side_w) + AreaW'(in_item_i.cell_x);
    lin_ext  = 32'(in_item_i.linear_index);
    xy_ext   = 32'(xy_index);
    if (cmd_e'(in_item_i.command) == CMD_ADD_IDX) begin
      in_ok   = lin_ext < 32'(area);
      in_addr = lin_ext[AddrW-1:0];
    end else begin
      in_ok   = (32'(in_item_i.cell_x) < 32'(side_w)) &&
                (32'(in_item_i.cell_y) < 32'(side_h));
      in_addr = xy_ext[AddrW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cmd_q   <= cmd_e'(in_item_i.command);
      s1_ok_q    <= in_ok;
      s1_addr_q  <= in_addr;
      s1_delta_q <= in_item_i.delta_value;
    end
  end

  // cell memory
  logic [CellW-1:0] mem_q [Depth];
  logic [CellW-1:0] rdata_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [CellW-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (in_accept) rdata_q <= mem_q[in_addr];
  end

  // last write, forwarded when a read raced it
  logic             wb_valid_q;
  logic [AddrW-1:0] wb_addr_q;
  logic [CellW-1:0] wb_data_q;

  // stage 1: modify and write back
  logic signed [CellW-1:0] cur_val, new_val;
  logic signed [CellW:0]   sum;
  logic signed [CellW:0]   lo_ext, hi_ext, lim;
  logic                    modify;

  always_comb begin
    if (wb_valid_q && wb_addr_q == s1_addr_q) cur_val = wb_data_q;
    else                                      cur_val = rdata_q;
    sum    = {cur_val[CellW-1], cur_val} + {s1_delta_q[CellW-1], s1_delta_q};
    lo_ext = {clamp_low_q[CellW-1], clamp_low_q};
    hi_ext = {clamp_high_q[CellW-1], clamp_high_q};
    // upper bound first, so crossed bounds end at the low bound
    lim = sum;
    if (lim > hi_ext) lim = hi_ext;
    if (lim < lo_ext) lim = lo_ext;
    modify = 1'b1;
    case (s1_cmd_q)
      CMD_ADD_XY, CMD_ADD_IDX: new_val = lim[CellW-1:0];
      CMD_SET:      new_val = s1_delta_q;
      CMD_SET_LOW:  new_val = clamp_low_q;
      CMD_SET_HIGH: new_val = clamp_high_q;
      default: begin
        new_val = cur_val;
        modify  = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (clearing_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_adv && s1_ok_q && modify;
      mem_waddr = s1_addr_q;
      mem_wdata = new_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
      wb_valid_q <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == AddrW'(Depth - 1)) clearing_q <= 1'b0;
      end
      if (mem_we && !clearing_q) wb_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && !clearing_q) begin
      wb_addr_q <= mem_waddr;
      wb_data_q <= mem_wdata;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      if (s1_ok_q) begin
        out_item_q.cell_value   <= new_val;
        out_item_q.out_of_range <= 1'b0;
      end else begin
        out_item_q.cell_value   <= '0;
        out_item_q.out_of_range <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !in_ready_o && !s1_valid_q)
    else $error("item taken during clearing pass");

  a_stage_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_addr_q))
    else $error("stalled item lost in stage one");

  a_oor_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && !s1_ok_q |-> !mem_we)
    else $error("out of range item wrote a cell");

  a_oor_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.out_of_range |-> out_item_q.cell_value == '0)
    else $error("out of range result carries a value");

endmodule

@@ tb/tb.sv @@
// tb: self-checking testbench for occupancy_grid_logodds_update, grid commands
// checked item by item against an in-bench model of the cell store and registers
// depends on ogl_pkg and the occupancy_grid_logodds_update rtl
module tb;
  import ogl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // clearing pass plus about 1960 items at worst-case gaps and stalls
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HotSpan    = 12;
  localparam int unsigned MaxSide    = MaxSideDefault;
  localparam logic [2:0]  CmdSpare6  = 3'd6;
  localparam logic [2:0]  CmdSpare7  = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  ogl_in_t             in_item_i;
  logic                out_valid_o;
  logic                out_ready_i;
  ogl_out_t            out_item_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  // model of the grid and its registers
  logic signed [CellW-1:0] cell_mem [0:MaxSide*MaxSide-1];
  logic [GridRegW-1:0]     grid_w;
  logic [GridRegW-1:0]     grid_h;
  logic signed [CellW-1:0] clamp_lo;
  logic signed [CellW-1:0] clamp_hi;

  ogl_out_t    cell_results_q [$];
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          steady;

  occupancy_grid_logodds_update dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned eff_side(logic [GridRegW-1:0] r);
    return (r > MaxSide) ? MaxSide : int'(r);
  endfunction

  // applies one command to the model grid, returns the result it gives
  function automatic ogl_out_t apply_grid_cmd(ogl_in_t c);
    int unsigned w;
    int unsigned h;
    int unsigned idx;
    bit          ok;
    int          v;
    ogl_out_t    r;
    w = eff_side(grid_w);
    h = eff_side(grid_h);
    r = '0;
    if (c.command == CMD_ADD_IDX) begin
      ok  = c.linear_index < w * h;
      idx = c.linear_index;
    end else begin
      ok  = (c.cell_x < w) && (c.cell_y < h);
      idx = c.cell_y * w + c.cell_x;
    end
    if (!ok) begin
      r.out_of_range = 1'b1;
      return r;
    end
    v = cell_mem[idx];
    case (c.command)
      CMD_ADD_XY, CMD_ADD_IDX: begin
        v = v + int'($signed(c.delta_value));
        if (v > clamp_hi) v = clamp_hi;
        if (v < clamp_lo) v = clamp_lo;
      end
      CMD_SET:      v = $signed(c.delta_value);
      CMD_SET_LOW:  v = clamp_lo;
      CMD_SET_HIGH: v = clamp_hi;
      default: ;
    endcase
    cell_mem[idx] = v[CellW-1:0];
    r.cell_value  = v[CellW-1:0];
    return r;
  endfunction

  function automatic ogl_in_t mk_cmd(logic [2:0] cmd, int unsigned x, int unsigned y,
                                     int unsigned lin, int delta);
    ogl_in_t c;
    c.command      = cmd;
    c.cell_x       = x[CoordW-1:0];
    c.cell_y       = y[CoordW-1:0];
    c.linear_index = lin[LinW-1:0];
    c.delta_value  = delta[CellW-1:0];
    return c;
  endfunction

  function automatic ogl_in_t random_cmd();
    ogl_in_t     c;
    int unsigned w;
    int unsigned h;
    w = eff_side(grid_w);
    h = eff_side(grid_h);
    case ($urandom_range(0, 15))
      0, 1:       c.command = CMD_READ;
      6, 7, 8:    c.command = CMD_ADD_IDX;
      9, 10:      c.command = CMD_SET;
      11:         c.command = CMD_SET_LOW;
      12:         c.command = CMD_SET_HIGH;
      13:         c.command = CmdSpare6;
      14:         c.command = CmdSpare7;
      default:    c.command = CMD_ADD_XY;
    endcase
    if ($urandom_range(0, 9) == 0) begin
      c.cell_x       = CoordW'($urandom);
      c.cell_y       = CoordW'($urandom);
      c.linear_index = LinW'($urandom);
    end else begin
      // small window so cells get hit again; on a small grid the upper end is one past the grid edge
      c.cell_x       = CoordW'($urandom_range(0, (w > HotSpan) ? HotSpan : w));
      c.cell_y       = CoordW'($urandom_range(0, (h > HotSpan) ? HotSpan : h));
      c.linear_index = LinW'($urandom_range(0, (w * h > HotSpan * HotSpan) ?
                                                HotSpan * HotSpan : w * h));
    end
    case ($urandom_range(0, 3))
      0:       c.delta_value = CellW'($urandom);
      1:       c.delta_value = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: c.delta_value = CellW'($urandom_range(0, 4095) - 2048);
    endcase
    return c;
  endfunction

  task automatic send_cmd(ogl_in_t c);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_item_i  = c;
    do @(posedge clk_i); while (!in_ready_o);
    cell_results_q.push_back(apply_grid_cmd(c));
  endtask

  task automatic drain_items();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (cell_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    case (idx)
      REG_GRID_WIDTH:  grid_w   = data[GridRegW-1:0];
      REG_GRID_HEIGHT: grid_h   = data[GridRegW-1:0];
      REG_CLAMP_LOW:   clamp_lo = data;
      default:         clamp_hi = data;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_grid(int unsigned w, int unsigned h, int lo, int hi);
    drain_items();
    write_reg(REG_GRID_WIDTH, CfgDataW'(w));
    write_reg(REG_GRID_HEIGHT, CfgDataW'(h));
    write_reg(REG_CLAMP_LOW, CfgDataW'(lo));
    write_reg(REG_CLAMP_HIGH, CfgDataW'(hi));
  endtask

  // reset-value registers: clamping, unclamped stores, spare codes, forwarding
  task automatic test_directed();
    set_grid(GridWidthReset, GridHeightReset, ClampLowReset, ClampHighReset);
    send_cmd(mk_cmd(CMD_READ, 0, 0, 0, 0));
    send_cmd(mk_cmd(CMD_ADD_XY, 0, 0, 0, 32767));
    send_cmd(mk_cmd(CMD_ADD_XY, 0, 0, 0, -32768));
    send_cmd(mk_cmd(CMD_SET, 0, 0, 0, 32767));
    send_cmd(mk_cmd(CMD_ADD_IDX, 0, 0, 0, 1));
    send_cmd(mk_cmd(CMD_SET, 255, 255, 0, -32768));
    send_cmd(mk_cmd(CMD_READ, 255, 255, 0, 0));
    send_cmd(mk_cmd(CMD_SET_LOW, 1, 0, 0, 0));
    send_cmd(mk_cmd(CMD_SET_HIGH, 0, 1, 0, 0));
    send_cmd(mk_cmd(CMD_ADD_IDX, 0, 0, 65535, 100));
    send_cmd(mk_cmd(CMD_ADD_IDX, 0, 0, 256, 5));
    send_cmd(mk_cmd(CmdSpare6, 1, 0, 0, 77));
    send_cmd(mk_cmd(CmdSpare7, 255, 255, 0, -77));
    // back-to-back updates of one cell
    steady = 1'b1;
    repeat (4) send_cmd(mk_cmd(CMD_ADD_XY, 2, 2, 0, 1000));
    send_cmd(mk_cmd(CMD_ADD_IDX, 0, 0, 2 * 256 + 2, -300));
    send_cmd(mk_cmd(CMD_READ, 2, 2, 0, 0));
    steady = 1'b0;
  endtask

  // edges of a small grid, an empty grid and oversized registers
  task automatic test_grid_bounds();
    set_grid(5, 3, -100, 100);
    send_cmd(mk_cmd(CMD_ADD_XY, 4, 2, 0, 500));
    send_cmd(mk_cmd(CMD_ADD_XY, 5, 0, 0, 1));
    send_cmd(mk_cmd(CMD_SET, 0, 3, 0, 9));
    send_cmd(mk_cmd(CMD_ADD_IDX, 0, 0, 14, -500));
    send_cmd(mk_cmd(CMD_ADD_IDX, 0, 0, 15, 1));
    set_grid(0, 3, -100, 100);
    send_cmd(mk_cmd(CMD_READ, 0, 0, 0, 0));
    send_cmd(mk_cmd(CMD_ADD_IDX, 0, 0, 0, 3));
    set_grid(4, 0, -100, 100);
    send_cmd(mk_cmd(CMD_SET_HIGH, 0, 0, 0, 0));
    set_grid(511, 300, ClampLowReset, ClampHighReset);
    send_cmd(mk_cmd(CMD_READ, 255, 255, 0, 0));
    send_cmd(mk_cmd(CMD_ADD_IDX, 0, 0, 65535, 7));
  endtask

  // crossed bounds give the low bound; full-range bounds saturate
  task automatic test_clamp_extremes();
    set_grid(8, 8, 1000, -1000);
    send_cmd(mk_cmd(CMD_ADD_XY, 1, 1, 0, 5));
    send_cmd(mk_cmd(CMD_SET_HIGH, 2, 1, 0, 0));
    send_cmd(mk_cmd(CMD_SET_LOW, 3, 1, 0, 0));
    set_grid(8, 8, -32768, 32767);
    steady = 1'b1;
    send_cmd(mk_cmd(CMD_SET, 1, 1, 0, 32000));
    send_cmd(mk_cmd(CMD_ADD_XY, 1, 1, 0, 32767));
    send_cmd(mk_cmd(CMD_SET, 1, 1, 0, -32000));
    send_cmd(mk_cmd(CMD_ADD_IDX, 0, 0, 9, -32768));
    steady = 1'b0;
  endtask

  task automatic test_random();
    int unsigned w;
    int unsigned h;
    int          lo;
    int          hi;
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 9))
        0:       w = MaxSide;
        1:       w = $urandom_range(MaxSide + 1, 511);
        default: w = $urandom_range(1, 16);
      endcase
      h = ($urandom_range(0, 7) == 0) ? MaxSide : $urandom_range(1, 16);
      case ($urandom_range(0, 3))
        0: begin
          lo = ClampLowReset;
          hi = ClampHighReset;
        end
        1: begin
          lo = -32768;
          hi = 32767;
        end
        2: begin
          lo = $signed(CellW'($urandom));
          hi = $signed(CellW'($urandom));
        end
        default: begin
          lo = -int'($urandom_range(0, 4000));
          hi = $urandom_range(0, 4000);
        end
      endcase
      set_grid(w, h, lo, hi);
      steady = (ph % 3 == 2);
      repeat (240) send_cmd(random_cmd());
      steady = 1'b0;
    end
  endtask

  // result checker with random back-pressure
  initial begin
    int unsigned stall;
    ogl_out_t    exp_r;
    ogl_out_t    got_r;
    out_ready_i = 1'b0;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 8);
      repeat (stall) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
      end
      @(negedge clk_i);
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got_r = out_item_o;
      if (cell_results_q.size() == 0) begin
        $error("result item with nothing expected: cell_value %0d out_of_range %0b",
               got_r.cell_value, got_r.out_of_range);
        fail_count++;
      end else begin
        exp_r = cell_results_q.pop_front();
        if (got_r.cell_value !== exp_r.cell_value) begin
          $error("cell_value: expected %0d, got %0d", exp_r.cell_value, got_r.cell_value);
          fail_count++;
        end
        if (got_r.out_of_range !== exp_r.out_of_range) begin
          $error("out_of_range: expected %0b, got %0b",
                 exp_r.out_of_range, got_r.out_of_range);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_GRID_WIDTH;
    cfg_wdata_i = '0;
    fail_count  = 0;
    cycle_count = 0;
    steady      = 1'b0;
    grid_w      = GridWidthReset;
    grid_h      = GridHeightReset;
    clamp_lo    = ClampLowReset;
    clamp_hi    = ClampHighReset;
    foreach (cell_mem[i]) cell_mem[i] = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_grid_bounds();
    test_clamp_extremes();
    test_random();

    drain_items();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
